// File: rtl/idt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idt_pkg: shared constants, codes and types of the identity table
// Field widths, table geometry, command and status codes, bitmap request type.
// ----------------------------------------------------------------------------
package idt_pkg;

  localparam int MAX_IDS     = 1024;
  localparam int HANDLE_BITS = 32;

  localparam int CMD_W  = 3;
  localparam int IDF_W  = 11;
  localparam int STAT_W = 2;

  localparam int ID_W   = $clog2(MAX_IDS);
  localparam int CNT_W  = ID_W + 1;
  localparam int WORD_W = 32;
  localparam int BIT_W  = $clog2(WORD_W);
  localparam int ROWS   = MAX_IDS / WORD_W;
  localparam int ROW_W  = $clog2(ROWS);

  localparam logic signed [IDF_W-1:0] ID_NONE = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_NEXT   = 3'd2,
    CMD_LOOKUP = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_NONE = 2'd1,
    STAT_FULL = 2'd2
  } status_t;

  typedef struct packed {
    logic              rd_en;
    logic [ROW_W-1:0]  rd_row;
    logic              wr_en;
    logic [ROW_W-1:0]  wr_row;
    logic [WORD_W-1:0] wr_data;
    logic              clr;
  } live_req_t;

  function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_W-1:0] w);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (w[i]) idx = BIT_W'(i);
    end
    return idx;
  endfunction

endpackage

// File: rtl/idt_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idt_in_if: command channel of the identity table
// Valid/ready handshake carrying cmd, id and handle_in.
// ----------------------------------------------------------------------------
interface idt_in_if;
  logic                                     valid;
  logic                                     ready;
  logic [idt_pkg::CMD_W-1:0]                cmd;
  logic signed [idt_pkg::IDF_W-1:0]         id;
  logic [idt_pkg::HANDLE_BITS-1:0]          handle_in;

  modport source (output valid, cmd, id, handle_in, input ready);
  modport sink (input valid, cmd, id, handle_in, output ready);
endinterface

// File: rtl/idt_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idt_out_if: result channel of the identity table
// Valid/ready handshake carrying status, id_out and handle_out.
// ----------------------------------------------------------------------------
interface idt_out_if;
  logic                                     valid;
  logic                                     ready;
  logic [idt_pkg::STAT_W-1:0]               status;
  logic signed [idt_pkg::IDF_W-1:0]         id_out;
  logic [idt_pkg::HANDLE_BITS-1:0]          handle_out;

  modport source (output valid, status, id_out, handle_out, input ready);
  modport sink (input valid, status, id_out, handle_out, output ready);
endinterface

// File: rtl/idt_live_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idt_live_map: live bitmap of the identity table
// Rows of bits in a memory with one registered read port and one write port;
// a per-row valid bit makes unwritten or cleared rows read as zero.
// ----------------------------------------------------------------------------
module idt_live_map (
  input  logic                           clk,
  input  logic                           rst_n,
  input  idt_pkg::live_req_t             req,
  output logic [idt_pkg::WORD_W-1:0]     rd_word
);

  logic [idt_pkg::WORD_W-1:0] mem [idt_pkg::ROWS];
  logic [idt_pkg::ROWS-1:0]   row_valid_r;
  logic [idt_pkg::WORD_W-1:0] rd_data_r;
  logic                       rd_valid_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) mem[req.wr_row] <= req.wr_data;
    if (req.rd_en) begin
      rd_data_r  <= mem[req.rd_row];
      rd_valid_r <= row_valid_r[req.rd_row];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
    end else if (req.clr) begin
      row_valid_r <= '0;
    end else if (req.wr_en) begin
      row_valid_r[req.wr_row] <= 1'b1;
    end
  end

  assign rd_word = rd_valid_r ? rd_data_r : '0;

endmodule

// File: rtl/id_table_with_free_stack.sv
`timescale 1ns / 1ps
// Steps: add EXEC, ADDW, OUT (with POP before ADDW to reuse a freed identity);
// remove and lookup EXEC, RMW or LKP, OUT; clear EXEC, OUT; next EXEC, SCAN,
// HND, OUT, one 32-entry bitmap row per cycle in SCAN; failures skip to OUT.
// One item at a time: the next item is accepted once the result is registered.
// Reset clears the bitmap row valid bits and counters at once; no clearing pass.
// ----------------------------------------------------------------------------
// id_table_with_free_stack: identity table with a LIFO free-identity stack
// Sequencer over handle memory, free stack memory and row-wise live bitmap.
// ----------------------------------------------------------------------------
module id_table_with_free_stack (
  input  logic          clk,
  input  logic          rst_n,
  idt_in_if.sink        in_ch,
  idt_out_if.source     out_ch
);

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_EXEC = 9'b000000010,
    ST_POP  = 9'b000000100,
    ST_ADDW = 9'b000001000,
    ST_RMW  = 9'b000010000,
    ST_LKP  = 9'b000100000,
    ST_SCAN = 9'b001000000,
    ST_HND  = 9'b010000000,
    ST_OUT  = 9'b100000000
  } state_t;

  localparam int IDF_W  = idt_pkg::IDF_W;
  localparam int ID_W   = idt_pkg::ID_W;
  localparam int CNT_W  = idt_pkg::CNT_W;
  localparam int WORD_W = idt_pkg::WORD_W;
  localparam int BIT_W  = idt_pkg::BIT_W;
  localparam int ROW_W  = idt_pkg::ROW_W;
  localparam int HB     = idt_pkg::HANDLE_BITS;
  localparam logic signed [IDF_W-1:0] ID_TOP = IDF_W'(idt_pkg::MAX_IDS - 1);

  state_t state_r, state_nxt;

  logic [idt_pkg::CMD_W-1:0]  cmd_r;
  logic signed [IDF_W-1:0]    id_r;
  logic [HB-1:0]              hin_r;

  logic [ID_W-1:0]            slot_r, slot_nxt;
  logic [ROW_W-1:0]           row_r, row_nxt;
  logic [BIT_W-1:0]           lo_r, lo_nxt;
  logic                       first_r, first_nxt;
  logic signed [IDF_W-1:0]    highest_r, highest_nxt;
  logic [CNT_W-1:0]           stack_r, stack_nxt;
  logic [CNT_W-1:0]           live_cnt_r, live_cnt_nxt;

  logic [idt_pkg::STAT_W-1:0] res_status_r, res_status_nxt;
  logic signed [IDF_W-1:0]    res_id_r, res_id_nxt;
  logic [HB-1:0]              res_handle_r, res_handle_nxt;

  logic                       out_valid_r;
  logic [idt_pkg::STAT_W-1:0] out_status_r;
  logic signed [IDF_W-1:0]    out_id_r;
  logic [HB-1:0]              out_handle_r;
  logic                       out_load;

  logic [HB-1:0]              hs_mem [idt_pkg::MAX_IDS];
  logic [HB-1:0]              hs_rd_r;
  logic                       hs_we, hs_re;
  logic [ID_W-1:0]            hs_raddr;

  logic [ID_W-1:0]            fs_mem [idt_pkg::MAX_IDS];
  logic [ID_W-1:0]            fs_rd_r;
  logic                       fs_we, fs_re;
  logic [ID_W-1:0]            fs_raddr;

  idt_pkg::live_req_t         live_req;
  logic [WORD_W-1:0]          live_rd;

  logic                       in_acc;
  logic [CNT_W-1:0]           eff_stack;
  logic signed [IDF_W-1:0]    eff_high;
  logic [ID_W-1:0]            new_slot;
  logic [ID_W-1:0]            start;
  logic [WORD_W-1:0]          bit_mask;
  logic [WORD_W-1:0]          scan_word;
  logic [ID_W-1:0]            cand;

  assign in_acc       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == ST_IDLE);

  assign eff_stack = (live_cnt_r == '0) ? '0 : stack_r;
  assign eff_high  = (live_cnt_r == '0) ? idt_pkg::ID_NONE : highest_r;
  assign new_slot  = eff_high[ID_W-1:0] + ID_W'(1);
  assign start     = id_r[ID_W-1:0] + ID_W'(1);
  assign bit_mask  = WORD_W'(1) << slot_r[BIT_W-1:0];
  assign scan_word = live_rd & (first_r ? ({WORD_W{1'b1}} << lo_r) : {WORD_W{1'b1}});
  assign cand      = {row_r, idt_pkg::lowest_set(scan_word)};

  idt_live_map u_live_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (live_req),
    .rd_word (live_rd)
  );

  always_comb begin
    state_nxt      = state_r;
    slot_nxt       = slot_r;
    row_nxt        = row_r;
    lo_nxt         = lo_r;
    first_nxt      = first_r;
    highest_nxt    = highest_r;
    stack_nxt      = stack_r;
    live_cnt_nxt   = live_cnt_r;
    res_status_nxt = res_status_r;
    res_id_nxt     = res_id_r;
    res_handle_nxt = res_handle_r;
    hs_we          = 1'b0;
    hs_re          = 1'b0;
    hs_raddr       = slot_r;
    fs_we          = 1'b0;
    fs_re          = 1'b0;
    fs_raddr       = '0;
    live_req       = '0;
    out_load       = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) state_nxt = ST_EXEC;
      end

      ST_EXEC: begin
        res_status_nxt = idt_pkg::STAT_NONE;
        res_id_nxt     = idt_pkg::ID_NONE;
        res_handle_nxt = '0;
        state_nxt      = ST_OUT;
        case (cmd_r)
          idt_pkg::CMD_ADD: begin
            stack_nxt   = eff_stack;
            highest_nxt = eff_high;
            if (eff_stack != '0) begin
              stack_nxt = eff_stack - CNT_W'(1);
              fs_re     = 1'b1;
              fs_raddr  = ID_W'(eff_stack - CNT_W'(1));
              state_nxt = ST_POP;
            end else if (eff_high == ID_TOP) begin
              res_status_nxt = idt_pkg::STAT_FULL;
            end else begin
              highest_nxt     = eff_high + IDF_W'(1);
              slot_nxt        = new_slot;
              live_req.rd_en  = 1'b1;
              live_req.rd_row = new_slot[ID_W-1:BIT_W];
              state_nxt       = ST_ADDW;
            end
          end
          idt_pkg::CMD_REMOVE, idt_pkg::CMD_LOOKUP: begin
            if (!id_r[IDF_W-1] && !(id_r > highest_r)) begin
              slot_nxt        = id_r[ID_W-1:0];
              live_req.rd_en  = 1'b1;
              live_req.rd_row = id_r[ID_W-1:BIT_W];
              hs_re           = (cmd_r == idt_pkg::CMD_LOOKUP);
              hs_raddr        = id_r[ID_W-1:0];
              state_nxt       = (cmd_r == idt_pkg::CMD_LOOKUP) ? ST_LKP : ST_RMW;
            end
          end
          idt_pkg::CMD_NEXT: begin
            if (!(id_r < idt_pkg::ID_NONE) && (id_r < highest_r)) begin
              row_nxt         = start[ID_W-1:BIT_W];
              lo_nxt          = start[BIT_W-1:0];
              first_nxt       = 1'b1;
              live_req.rd_en  = 1'b1;
              live_req.rd_row = start[ID_W-1:BIT_W];
              state_nxt       = ST_SCAN;
            end
          end
          idt_pkg::CMD_CLEAR: begin
            live_req.clr   = 1'b1;
            stack_nxt      = '0;
            highest_nxt    = idt_pkg::ID_NONE;
            live_cnt_nxt   = '0;
            res_status_nxt = idt_pkg::STAT_OK;
          end
          default: begin
            res_status_nxt = idt_pkg::STAT_NONE;
          end
        endcase
      end

      ST_POP: begin
        slot_nxt        = fs_rd_r;
        live_req.rd_en  = 1'b1;
        live_req.rd_row = fs_rd_r[ID_W-1:BIT_W];
        state_nxt       = ST_ADDW;
      end

      ST_ADDW: begin
        live_req.wr_en   = 1'b1;
        live_req.wr_row  = slot_r[ID_W-1:BIT_W];
        live_req.wr_data = live_rd | bit_mask;
        hs_we            = 1'b1;
        live_cnt_nxt     = live_cnt_r + CNT_W'(1);
        res_status_nxt   = idt_pkg::STAT_OK;
        res_id_nxt       = $signed(IDF_W'(slot_r));
        state_nxt        = ST_OUT;
      end

      ST_RMW: begin
        state_nxt = ST_OUT;
        if ((live_rd & bit_mask) != '0) begin
          live_req.wr_en   = 1'b1;
          live_req.wr_row  = slot_r[ID_W-1:BIT_W];
          live_req.wr_data = live_rd & ~bit_mask;
          if ($signed(IDF_W'(slot_r)) == highest_r) begin
            highest_nxt = highest_r - IDF_W'(1);
          end else if (stack_r < CNT_W'(idt_pkg::MAX_IDS)) begin
            fs_we     = 1'b1;
            stack_nxt = stack_r + CNT_W'(1);
          end
          if (live_cnt_r != '0) live_cnt_nxt = live_cnt_r - CNT_W'(1);
          res_status_nxt = idt_pkg::STAT_OK;
        end
      end

      ST_LKP: begin
        state_nxt = ST_OUT;
        if ((live_rd & bit_mask) != '0) begin
          res_status_nxt = idt_pkg::STAT_OK;
          res_handle_nxt = hs_rd_r;
        end
      end

      ST_SCAN: begin
        if (scan_word != '0) begin
          if (!($signed(IDF_W'(cand)) > highest_r)) begin
            slot_nxt  = cand;
            hs_re     = 1'b1;
            hs_raddr  = cand;
            state_nxt = ST_HND;
          end else begin
            state_nxt = ST_OUT;
          end
        end else if (row_r == highest_r[ID_W-1:BIT_W]) begin
          state_nxt = ST_OUT;
        end else begin
          row_nxt         = row_r + ROW_W'(1);
          first_nxt       = 1'b0;
          live_req.rd_en  = 1'b1;
          live_req.rd_row = row_r + ROW_W'(1);
        end
      end

      ST_HND: begin
        res_status_nxt = idt_pkg::STAT_OK;
        res_id_nxt     = $signed(IDF_W'(slot_r));
        res_handle_nxt = hs_rd_r;
        state_nxt      = ST_OUT;
      end

      ST_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (hs_we) hs_mem[slot_r] <= hin_r;
    if (hs_re) hs_rd_r <= hs_mem[hs_raddr];
    if (fs_we) fs_mem[stack_r[ID_W-1:0]] <= slot_r;
    if (fs_re) fs_rd_r <= fs_mem[fs_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      highest_r   <= idt_pkg::ID_NONE;
      stack_r     <= '0;
      live_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      highest_r  <= highest_nxt;
      stack_r    <= stack_nxt;
      live_cnt_r <= live_cnt_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r <= in_ch.cmd;
      id_r  <= in_ch.id;
      hin_r <= in_ch.handle_in;
    end
    slot_r       <= slot_nxt;
    row_r        <= row_nxt;
    lo_r         <= lo_nxt;
    first_r      <= first_nxt;
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    res_handle_r <= res_handle_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_id_r     <= res_id_r;
      out_handle_r <= res_handle_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.id_out     = out_id_r;
  assign out_ch.handle_out = out_handle_r;

endmodule

// File: rtl/idt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idt_checker: port-level checks of the identity table
// Watches the command and result channels; bound to the top level.
// ----------------------------------------------------------------------------
module idt_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [idt_pkg::STAT_W-1:0]          out_status,
  input logic signed [idt_pkg::IDF_W-1:0]    out_id,
  input logic [idt_pkg::HANDLE_BITS-1:0]     out_handle
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_id))
    else $error("result item dropped or changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item accepted while one is in work");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3)
    else $error("undefined status code");

  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != idt_pkg::STAT_OK |->
      out_id == idt_pkg::ID_NONE && out_handle == '0)
    else $error("failed item carries an identity or handle");

endmodule

bind id_table_with_free_stack idt_checker u_idt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_id     (out_ch.id_out),
  .out_handle (out_ch.handle_out)
);

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the identity table with a free-identity stack
// A bursty sender feeds command items. A shadow table of handles, live bitmap,
// free stack and high mark predicts each reply, and replies are checked in
// order while the receiver stalls and, once, holds off long enough to block
// the input. Directed checks cover the empty table, identity reuse, the
// lowered high mark, restart after draining, clear and a full table. A random
// mix with swinging population follows.
// ----------------------------------------------------------------------------
module tb_top;
  import idt_pkg::*;

  localparam int     HALF_PERIOD  = 6;
  localparam int     RESET_CYCLES = 7;
  localparam int     DRAIN_CYCLES = 48;
  localparam int     RUN_LIMIT_NS = 20_000_000;
  localparam int     RANDOM_ITEMS = 160;
  localparam int     PHASE_ITEMS  = 16;
  localparam int     LONG_HOLD    = 400;
  localparam int     MAX_PRINTED  = 100;
  localparam int     PHASE_ADDS [10] = '{60, 10, 55, 5, 10, 70, 5, 5, 40, 10};

  localparam logic [CMD_W-1:0]        CMD_SPARE_5 = 3'd5;
  localparam logic signed [IDF_W-1:0] ID_MOST_NEG = 11'sh400;
  localparam logic signed [IDF_W-1:0] ID_MOST_POS = 11'sh3FF;

  typedef enum int {RX_FREE, RX_LIGHT, RX_BURSTY} rx_mode_t;

  typedef struct {
    logic [STAT_W-1:0]       status;
    logic signed [IDF_W-1:0] id;
    logic [HANDLE_BITS-1:0]  handle;
    logic [CMD_W-1:0]        cmd;
    int                      seq;
  } table_reply_t;

  logic clk = 1'b0;
  logic rst_n;

  idt_in_if  in_ch ();
  idt_out_if out_ch ();

  id_table_with_free_stack i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic [HANDLE_BITS-1:0] shadow_handle [MAX_IDS];
  logic [MAX_IDS-1:0]     shadow_live = '0;
  logic [ID_W-1:0]        shadow_free [MAX_IDS];
  int                     shadow_free_cnt = 0;
  int                     shadow_top = -1;
  int                     shadow_pop = 0;

  table_reply_t replies_due [$];

  int items_sent = 0;
  int replies_checked = 0;
  int err_count = 0;
  int full_replies = 0;
  int restarts = 0;
  int peak_pop = 0;

  int       tx_gap_max = 0;
  int       tx_burst_left = 0;
  rx_mode_t rx_mode = RX_FREE;
  int       hold_len = 0;
  int       rx_run = 0;
  bit       rx_high = 1'b0;

  always #HALF_PERIOD clk = ~clk;

  function automatic bit is_live(input int v);
    return (v >= 0 && v <= shadow_top) ? shadow_live[v] : 1'b0;
  endfunction

  task automatic predict_reply(input logic [CMD_W-1:0] c, input logic signed [IDF_W-1:0] v_in,
                               input logic [HANDLE_BITS-1:0] h, output table_reply_t r);
    int v;
    int slot;
    int s;
    bit placed;
    bit found;
    v        = v_in;
    r.status = STAT_NONE;
    r.id     = ID_NONE;
    r.handle = '0;
    r.cmd    = c;
    r.seq    = items_sent;
    placed   = 1'b0;
    found    = 1'b0;
    slot     = 0;
    case (c)
      CMD_ADD: begin
        if (shadow_pop == 0) begin
          if (shadow_top != -1 || shadow_free_cnt != 0) restarts++;
          shadow_free_cnt = 0;
          shadow_top      = -1;
        end
        if (shadow_free_cnt > 0) begin
          shadow_free_cnt--;
          slot   = shadow_free[shadow_free_cnt];
          placed = 1'b1;
        end else if (shadow_top + 1 < MAX_IDS) begin
          shadow_top++;
          slot   = shadow_top;
          placed = 1'b1;
        end else begin
          r.status = STAT_FULL;
          full_replies++;
        end
        if (placed) begin
          shadow_handle[slot] = h;
          shadow_live[slot]   = 1'b1;
          shadow_pop++;
          if (shadow_pop > peak_pop) peak_pop = shadow_pop;
          r.status = STAT_OK;
          r.id     = IDF_W'(slot);
        end
      end
      CMD_REMOVE: begin
        if (is_live(v)) begin
          shadow_live[v] = 1'b0;
          if (v == shadow_top) begin
            shadow_top--;
          end else if (shadow_free_cnt < MAX_IDS) begin
            shadow_free[shadow_free_cnt] = ID_W'(v);
            shadow_free_cnt++;
          end
          if (shadow_pop > 0) shadow_pop--;
          r.status = STAT_OK;
        end
      end
      CMD_NEXT: begin
        if (v >= -1 && v <= shadow_top) begin
          for (s = v + 1; s <= shadow_top && !found; s++) begin
            if (shadow_live[s]) begin
              found = 1'b1;
              slot  = s;
            end
          end
          if (found) begin
            r.status = STAT_OK;
            r.id     = IDF_W'(slot);
            r.handle = shadow_handle[slot];
          end
        end
      end
      CMD_LOOKUP: begin
        if (is_live(v)) begin
          r.status = STAT_OK;
          r.handle = shadow_handle[v];
        end
      end
      CMD_CLEAR: begin
        shadow_live     = '0;
        shadow_free_cnt = 0;
        shadow_top      = -1;
        shadow_pop      = 0;
        r.status        = STAT_OK;
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what);
    if (err_count < MAX_PRINTED) $display("ERROR at %0t: %s", $time, what);
    err_count++;
  endtask

  task automatic send_item(input logic [CMD_W-1:0] c, input logic signed [IDF_W-1:0] v,
                           input logic [HANDLE_BITS-1:0] h);
    table_reply_t r;
    int gap;
    @(negedge clk);
    in_ch.valid     <= 1'b1;
    in_ch.cmd       <= c;
    in_ch.id        <= v;
    in_ch.handle_in <= h;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predict_reply(c, v, h, r);
    replies_due.push_back(r);
    items_sent++;
    if (tx_burst_left > 0) tx_burst_left--;
    if (tx_burst_left == 0) begin
      tx_burst_left = $urandom_range(1, 16);
      gap = (tx_gap_max > 0) ? $urandom_range(0, tx_gap_max) : 0;
      if (gap > 0) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  function automatic logic signed [IDF_W-1:0] choose_id();
    int pick;
    int start;
    int k;
    int idx;
    pick = $urandom_range(0, 9);
    if (pick < 7 && shadow_pop > 0) begin
      start = $urandom_range(0, shadow_top);
      for (k = 0; k <= shadow_top; k++) begin
        idx = (start + k) % (shadow_top + 1);
        if (shadow_live[idx]) return IDF_W'(idx);
      end
    end
    if (pick == 9) begin
      case ($urandom_range(0, 4))
        0:       return ID_NONE;
        1:       return IDF_W'(shadow_top);
        2:       return IDF_W'(shadow_top + 1);
        3:       return ID_MOST_POS;
        default: return ID_MOST_NEG;
      endcase
    end
    if (pick == 8) return IDF_W'($urandom);
    return IDF_W'($urandom_range(0, shadow_top + 1) - 1);
  endfunction

  function automatic logic [HANDLE_BITS-1:0] pick_handle();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random_item(input int add_pct);
    int r;
    r = $urandom_range(0, 999);
    if (r < add_pct * 10) begin
      send_item(CMD_ADD, IDF_W'($urandom), pick_handle());
    end else if (r < 990) begin
      case ($urandom_range(0, 3))
        0, 1:    send_item(CMD_REMOVE, choose_id(), $urandom);
        2:       send_item(CMD_NEXT, choose_id(), $urandom);
        default: send_item(CMD_LOOKUP, choose_id(), $urandom);
      endcase
    end else if (r < 995) begin
      send_item(CMD_CLEAR, IDF_W'($urandom), $urandom);
    end else begin
      send_item(CMD_W'(CMD_SPARE_5 + $urandom_range(0, 2)), IDF_W'($urandom), $urandom);
    end
  endtask

  always @(negedge clk) begin
    if (hold_len > 0) begin
      hold_len = hold_len - 1;
      out_ch.ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_FREE:  out_ch.ready <= 1'b1;
        RX_LIGHT: out_ch.ready <= ($urandom_range(0, 3) != 0);
        default: begin
          if (rx_run == 0) begin
            rx_high = !rx_high;
            rx_run  = rx_high ? $urandom_range(1, 4) : $urandom_range(1, 8);
          end
          rx_run = rx_run - 1;
          out_ch.ready <= rx_high;
        end
      endcase
    end
  end

  always @(posedge clk) begin : check_replies
    table_reply_t due;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (replies_due.size() == 0) begin
        report_mismatch("reply with no command outstanding");
      end else begin
        due = replies_due.pop_front();
        replies_checked++;
        if (out_ch.status !== due.status)
          report_mismatch($sformatf("item %0d cmd %0d: status %0d, want %0d",
                                    due.seq, due.cmd, out_ch.status, due.status));
        if (out_ch.id_out !== due.id)
          report_mismatch($sformatf("item %0d cmd %0d: id_out %0d, want %0d",
                                    due.seq, due.cmd, out_ch.id_out, due.id));
        if (out_ch.handle_out !== due.handle)
          report_mismatch($sformatf("item %0d cmd %0d: handle_out %h, want %h",
                                    due.seq, due.cmd, out_ch.handle_out, due.handle));
      end
    end
  end

  task automatic test_empty_table();
    tx_gap_max = 0;
    rx_mode    = RX_FREE;
    send_item(CMD_NEXT, ID_NONE, '0);
    send_item(CMD_LOOKUP, 11'sd0, '0);
    send_item(CMD_REMOVE, 11'sd0, '0);
    send_item(CMD_SPARE_5, 11'sd0, '1);
  endtask

  task automatic test_basic_ops();
    tx_gap_max = 3;
    rx_mode    = RX_BURSTY;
    send_item(CMD_ADD, 11'sd0, '0);
    send_item(CMD_ADD, 11'sd0, '1);
    send_item(CMD_ADD, 11'sd0, pick_handle());
    send_item(CMD_ADD, 11'sd0, 32'h8000_0001);
    send_item(CMD_LOOKUP, 11'sd1, '0);
    send_item(CMD_NEXT, ID_NONE, '0);
    send_item(CMD_NEXT, ID_MOST_NEG, '0);
    send_item(CMD_REMOVE, 11'sd0, '0);
    send_item(CMD_REMOVE, 11'sd1, '0);
    send_item(CMD_NEXT, ID_NONE, '0);
    send_item(CMD_REMOVE, 11'sd3, '0);
    send_item(CMD_REMOVE, 11'sd2, '0);
    // drained with a stale stack: numbering restarts at zero
    send_item(CMD_ADD, 11'sd0, pick_handle());
    send_item(CMD_ADD, 11'sd0, pick_handle());
    send_item(CMD_ADD, 11'sd0, pick_handle());
    // high mark drops onto a freed identity
    send_item(CMD_REMOVE, 11'sd1, '0);
    send_item(CMD_REMOVE, 11'sd2, '0);
    send_item(CMD_NEXT, 11'sd0, '0);
    send_item(CMD_ADD, 11'sd0, pick_handle());
    send_item(CMD_CLEAR, 11'sd0, '0);
    send_item(CMD_LOOKUP, 11'sd0, '0);
  endtask

  task automatic test_full_table();
    int k;
    tx_gap_max = 2;
    rx_mode    = RX_LIGHT;
    send_item(CMD_CLEAR, 11'sd0, '0);
    for (k = 0; k < MAX_IDS; k++) send_item(CMD_ADD, IDF_W'($urandom), pick_handle());
    send_item(CMD_ADD, 11'sd0, pick_handle());
    send_item(CMD_NEXT, 11'sd1022, '0);
    send_item(CMD_LOOKUP, ID_MOST_POS, '0);
    send_item(CMD_REMOVE, 11'sd500, '0);
    send_item(CMD_ADD, 11'sd0, pick_handle());
    send_item(CMD_ADD, 11'sd0, pick_handle());
    for (k = 0; k < 20; k++) send_random_item(30);
  endtask

  task automatic test_backpressure();
    int k;
    tx_gap_max = 0;
    rx_mode    = RX_FREE;
    hold_len   = LONG_HOLD;
    for (k = 0; k < 30; k++) send_random_item(50);
  endtask

  task automatic test_random();
    int n;
    int phase;
    int add_pct;
    add_pct = 50;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % PHASE_ITEMS == 0) begin
        phase      = (n / PHASE_ITEMS) % 10;
        add_pct    = PHASE_ADDS[phase];
        tx_gap_max = (phase % 3 == 0) ? 0 : ((phase % 3 == 1) ? 3 : 12);
        rx_mode    = (phase == 0) ? RX_FREE : rx_mode_t'($urandom_range(0, 2));
      end
      send_random_item(add_pct);
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.cmd       = '0;
    in_ch.id        = '0;
    in_ch.handle_in = '0;
    out_ch.ready    = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_table();
    test_basic_ops();
    test_full_table();
    test_backpressure();
    test_random();

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d items and %0d replies: directed ops, full table, long hold-off, %s",
             items_sent, replies_checked, "random mix");
    $display("Table-full replies %0d, restarts after draining %0d, peak population %0d",
             full_replies, restarts, peak_pop);
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("FAILURE");
    $finish;
  end

endmodule
